// File: sv/dag_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dag_pkg: shared types and codes for the dataflow graph keeper
// Field widths, opcodes, result codes, controller states and datapath steps.
// ----------------------------------------------------------------------------
package dag_pkg;

	localparam int OP_W   = 2;
	localparam int ID_W   = 5;
	localparam int PORT_W = 3;
	localparam int ST_W   = 2;
	localparam int CNT_W  = 9;

	localparam int NODES_DEF      = 32;
	localparam int NODE_PORTS_DEF = 8;

	localparam logic [OP_W-1:0] OP_ADD_NODE = 2'd0;
	localparam logic [OP_W-1:0] OP_ADD_EDGE = 2'd1;
	localparam logic [OP_W-1:0] OP_RM_EDGE  = 2'd2;
	localparam logic [OP_W-1:0] OP_RM_NODE  = 2'd3;

	localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
	localparam logic [ST_W-1:0] ST_ORDER = 2'd1;
	localparam logic [ST_W-1:0] ST_MISS  = 2'd2;
	localparam logic [ST_W-1:0] ST_CYCLE = 2'd3;

	typedef enum logic [4:0] {
		S_IDLE, S_DEC,
		S_AN_CLR,
		S_RE_RD, S_RE_WR,
		S_RN_PRD, S_RN_PCHK, S_RN_EDEC, S_RN_SRD, S_RN_SCHK, S_RN_FIN,
		S_CP_RD, S_CP_WR, S_SQ_RD, S_SQ_N, S_P_RD, S_P_CHK, S_P_DEC,
		S_FIN, S_CM_RD, S_CM_WR, S_EM_RD, S_EM_LD,
		S_DONE, S_MISS, S_CYC
	} state_t;

	typedef enum logic [4:0] {
		ACT_NONE, ACT_LOAD, ACT_INIT,
		ACT_AN_CLR,
		ACT_RE_RD, ACT_RE_WR,
		ACT_RN_PRD, ACT_RN_PCHK, ACT_RN_EDEC, ACT_RN_SRD, ACT_RN_SCHK, ACT_RN_FIN,
		ACT_CP_RD, ACT_CP_WR, ACT_SQ_RD, ACT_SQ_N, ACT_P_RD, ACT_P_CHK, ACT_P_DEC,
		ACT_CM_RD, ACT_CM_WR, ACT_EM_RD, ACT_EM_LD,
		ACT_OUT_DONE, ACT_OUT_MISS, ACT_OUT_CYC
	} act_t;

	typedef struct packed {
		logic [OP_W-1:0] opcode;
		logic id_in;
		logic id_ok;
		logic src_ok;
		logic prt_ok;
		logic last_port;
		logic last_node;
		logic last_slot;
		logic q_empty;
		logic sort_ok;
		logic last_emit;
		logic hit;
		logic rn_linked;
		logic out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

// File: sv/dag_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dag_req_if: operation request channel
// Valid/ready channel carrying one graph operation per transfer.
// ----------------------------------------------------------------------------
interface dag_req_if import dag_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [ID_W-1:0]   node_id;
	logic [ID_W-1:0]   source_node;
	logic [PORT_W-1:0] port;

	modport source (output valid, opcode, node_id, source_node, port, input ready);
	modport sink   (input valid, opcode, node_id, source_node, port, output ready);
endinterface
`default_nettype wire

// File: sv/dag_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dag_rsp_if: result channel
// Valid/ready channel carrying one status or run order entry per transfer.
// ----------------------------------------------------------------------------
interface dag_rsp_if import dag_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [ST_W-1:0] status;
	logic [ID_W-1:0] order_node;
	logic            last;

	modport source (output valid, status, order_node, last, input ready);
	modport sink   (input valid, status, order_node, last, output ready);
endinterface
`default_nettype wire

// File: sv/dag_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dag_ram: generic simple dual port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dag_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// File: sv/dag_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dag_ctrl: operation sequencer
// Steps the datapath through each operation and the checked sort.
// ----------------------------------------------------------------------------
module dag_ctrl import dag_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  dp_stat_t stat,
	output act_t     act
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:    if (req_valid) state_d = S_DEC;
			S_DEC: begin
				unique case (stat.opcode)
					OP_ADD_NODE: state_d = stat.id_in ? S_AN_CLR : S_DONE;
					OP_ADD_EDGE: state_d = (stat.id_ok && stat.src_ok && stat.prt_ok)
						? S_CP_RD : S_MISS;
					OP_RM_EDGE:  state_d = S_RE_RD;
					OP_RM_NODE:  state_d = stat.id_ok ? S_RN_PRD : S_DONE;
					default:     state_d = S_DONE;
				endcase
			end
			S_AN_CLR:  if (stat.last_port) state_d = S_DONE;
			S_RE_RD:   state_d = S_RE_WR;
			S_RE_WR:   state_d = S_DONE;
			S_RN_PRD:  state_d = S_RN_PCHK;
			S_RN_PCHK: begin
				if (stat.rn_linked) state_d = S_RN_EDEC;
				else state_d = stat.last_port ? S_RN_SRD : S_RN_PRD;
			end
			S_RN_EDEC: state_d = stat.last_port ? S_RN_SRD : S_RN_PRD;
			S_RN_SRD:  state_d = S_RN_SCHK;
			S_RN_SCHK: state_d = stat.last_slot ? S_RN_FIN : S_RN_SRD;
			S_RN_FIN:  state_d = S_DONE;
			S_CP_RD:   state_d = S_CP_WR;
			S_CP_WR:   state_d = stat.last_node ? S_SQ_RD : S_CP_RD;
			S_SQ_RD:   state_d = stat.q_empty ? S_FIN : S_SQ_N;
			S_SQ_N:    state_d = S_P_RD;
			S_P_RD:    state_d = S_P_CHK;
			S_P_CHK: begin
				if (stat.hit) state_d = S_P_DEC;
				else state_d = stat.last_port ? S_SQ_RD : S_P_RD;
			end
			S_P_DEC:   state_d = stat.last_port ? S_SQ_RD : S_P_RD;
			S_FIN:     state_d = stat.sort_ok ? S_CM_RD : S_CYC;
			S_CM_RD:   state_d = S_CM_WR;
			S_CM_WR:   state_d = S_EM_RD;
			S_EM_RD:   state_d = S_EM_LD;
			S_EM_LD: begin
				if (stat.out_free) state_d = stat.last_emit ? S_IDLE : S_EM_RD;
			end
			S_DONE, S_MISS, S_CYC: if (stat.out_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		act       = ACT_NONE;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				act       = req_valid ? ACT_LOAD : ACT_NONE;
			end
			S_DEC:     act = ACT_INIT;
			S_AN_CLR:  act = ACT_AN_CLR;
			S_RE_RD:   act = ACT_RE_RD;
			S_RE_WR:   act = ACT_RE_WR;
			S_RN_PRD:  act = ACT_RN_PRD;
			S_RN_PCHK: act = ACT_RN_PCHK;
			S_RN_EDEC: act = ACT_RN_EDEC;
			S_RN_SRD:  act = ACT_RN_SRD;
			S_RN_SCHK: act = ACT_RN_SCHK;
			S_RN_FIN:  act = ACT_RN_FIN;
			S_CP_RD:   act = ACT_CP_RD;
			S_CP_WR:   act = ACT_CP_WR;
			S_SQ_RD:   act = ACT_SQ_RD;
			S_SQ_N:    act = ACT_SQ_N;
			S_P_RD:    act = ACT_P_RD;
			S_P_CHK:   act = ACT_P_CHK;
			S_P_DEC:   act = ACT_P_DEC;
			S_FIN:     act = ACT_NONE;
			S_CM_RD:   act = ACT_CM_RD;
			S_CM_WR:   act = ACT_CM_WR;
			S_EM_RD:   act = ACT_EM_RD;
			S_EM_LD:   act = stat.out_free ? ACT_EM_LD : ACT_NONE;
			S_DONE:    act = stat.out_free ? ACT_OUT_DONE : ACT_NONE;
			S_MISS:    act = stat.out_free ? ACT_OUT_MISS : ACT_NONE;
			S_CYC:     act = stat.out_free ? ACT_OUT_CYC : ACT_NONE;
			default:   act = ACT_NONE;
		endcase
	end
endmodule
`default_nettype wire

// File: sv/dag_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dag_dp: graph store and sort datapath
// Node flags, count/port/work/queue RAMs, walk counters and result register.
// ----------------------------------------------------------------------------
module dag_dp import dag_pkg::*; #(
	parameter int NODES      = NODES_DEF,
	parameter int NODE_PORTS = NODE_PORTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  act_t              act,
	input  logic [OP_W-1:0]   opcode,
	input  logic [ID_W-1:0]   node_id,
	input  logic [ID_W-1:0]   source_node,
	input  logic [PORT_W-1:0] port,
	output dp_stat_t          stat,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic [ST_W-1:0]   rsp_status,
	output logic [ID_W-1:0]   rsp_order_node,
	output logic              rsp_last
);
	localparam int IW    = $clog2(NODES);
	localparam int PW    = (NODE_PORTS > 1) ? $clog2(NODE_PORTS) : 1;
	localparam int SLOTS = NODES * NODE_PORTS;
	localparam int SW    = $clog2(SLOTS);
	localparam int CW    = $clog2(NODES + 1);

	logic [OP_W-1:0]   op_q;
	logic [ID_W-1:0]   id_q, src_q;
	logic [PORT_W-1:0] prt_q;
	logic [NODES-1:0]  present_q;
	logic [IW-1:0]     i_q, n_q, s_q;
	logic [PW-1:0]     p_q;
	logic [SW-1:0]     k_q;
	logic [CW-1:0]     head_q, tail_q, pc_q;
	logic              s_ok_q;
	logic              out_valid_q, out_last_q;
	logic [ST_W-1:0]   out_status_q;
	logic [ID_W-1:0]   out_node_q;

	logic              e_we, e_re, w_we, w_re, q_we, q_re, pt_we, pt_re;
	logic [IW-1:0]     e_wa, e_ra, w_wa, w_ra, q_wa, q_ra;
	logic [SW-1:0]     pt_wa, pt_ra;
	logic [CNT_W-1:0]  e_wd, w_wd, edges_rd, work_rd;
	logic [IW-1:0]     q_wd, queue_rd;
	logic [IW:0]       pt_wd, port_rd;

	function automatic logic present_of(input logic [IW-1:0] x);
		return (32'(x) < NODES) && present_q[x];
	endfunction

	function automatic logic [SW-1:0] slot_of(input logic [IW-1:0] n, input logic [PW-1:0] p);
		return SW'(32'(n) * NODE_PORTS + 32'(p));
	endfunction

	logic             id_in, src_in, id_ok, src_ok, prt_ok;
	logic [IW-1:0]    idn, srcn, port_src, eff_src;
	logic [PW-1:0]    pidx, p_nxt;
	logic [SW-1:0]    slot_new, cur_slot;
	logic             port_lnk, ovr, hit, last_port, out_free, seed_q, push_q;
	logic [CNT_W-1:0] cp_val, dec_val;
	logic [CW-1:0]    em_idx;

	assign id_in    = 32'(id_q) < NODES;
	assign src_in   = 32'(src_q) < NODES;
	assign idn      = IW'(id_q);
	assign srcn     = IW'(src_q);
	assign pidx     = PW'(prt_q);
	assign id_ok    = id_in && present_q[idn];
	assign src_ok   = src_in && present_q[srcn];
	assign prt_ok   = 32'(prt_q) < NODE_PORTS;
	assign slot_new = slot_of(idn, pidx);
	assign cur_slot = slot_of(n_q, p_q);
	assign port_lnk = port_rd[IW];
	assign port_src = port_rd[IW-1:0];
	// the edge under test stands in for whatever the port holds now
	assign ovr      = cur_slot == slot_new;
	assign eff_src  = ovr ? srcn : port_src;
	assign hit      = (ovr || port_lnk) && present_of(eff_src);
	assign last_port = p_q == PW'(NODE_PORTS - 1);
	assign p_nxt    = last_port ? '0 : p_q + PW'(1);
	assign cp_val   = edges_rd + CNT_W'(i_q == srcn);
	assign dec_val  = work_rd - CNT_W'(1);
	assign seed_q   = present_q[i_q] && (cp_val == '0);
	assign push_q   = (dec_val == '0) && (32'(tail_q) < NODES);
	assign em_idx   = tail_q - CW'(1) - CW'(i_q);
	assign out_free = !out_valid_q || rsp_ready;

	always_comb begin
		stat.opcode    = op_q;
		stat.id_in     = id_in;
		stat.id_ok     = id_ok;
		stat.src_ok    = src_ok;
		stat.prt_ok    = prt_ok;
		stat.last_port = last_port;
		stat.last_node = i_q == IW'(NODES - 1);
		stat.last_slot = k_q == SW'(SLOTS - 1);
		stat.q_empty   = head_q == tail_q;
		stat.sort_ok   = tail_q == pc_q;
		stat.last_emit = (CW'(i_q) + CW'(1)) == tail_q;
		stat.hit       = hit;
		stat.rn_linked = port_lnk;
		stat.out_free  = out_free;
	end

	always_comb begin
		e_we = 1'b0; e_re = 1'b0; e_wa = '0; e_ra = '0; e_wd = '0;
		w_we = 1'b0; w_re = 1'b0; w_wa = '0; w_ra = '0; w_wd = '0;
		q_we = 1'b0; q_re = 1'b0; q_wa = '0; q_ra = '0; q_wd = '0;
		pt_we = 1'b0; pt_re = 1'b0; pt_wa = '0; pt_ra = '0; pt_wd = '0;
		unique case (act)
			ACT_AN_CLR: begin
				e_we = 1'b1; e_wa = idn;
				pt_we = 1'b1; pt_wa = slot_of(idn, p_q);
			end
			ACT_RE_RD: begin
				e_re = 1'b1; e_ra = srcn;
			end
			ACT_RE_WR: begin
				e_we = src_ok && (edges_rd != '0); e_wa = srcn; e_wd = edges_rd - CNT_W'(1);
				pt_we = id_ok && prt_ok; pt_wa = slot_new;
			end
			ACT_RN_PRD: begin
				pt_re = 1'b1; pt_ra = slot_of(idn, p_q);
			end
			ACT_RN_PCHK: begin
				e_re = 1'b1; e_ra = port_src;
				pt_we = port_lnk; pt_wa = slot_of(idn, p_q);
			end
			ACT_RN_EDEC: begin
				e_we = s_ok_q && (edges_rd != '0); e_wa = s_q; e_wd = edges_rd - CNT_W'(1);
			end
			ACT_RN_SRD: begin
				pt_re = 1'b1; pt_ra = k_q;
			end
			ACT_RN_SCHK: begin
				pt_we = port_lnk && (port_src == idn); pt_wa = k_q;
			end
			ACT_RN_FIN: begin
				e_we = 1'b1; e_wa = idn;
			end
			ACT_CP_RD: begin
				e_re = 1'b1; e_ra = i_q;
			end
			ACT_CP_WR: begin
				w_we = 1'b1; w_wa = i_q; w_wd = cp_val;
				q_we = seed_q; q_wa = IW'(tail_q); q_wd = i_q;
			end
			ACT_SQ_RD: begin
				q_re = head_q != tail_q; q_ra = IW'(head_q);
			end
			ACT_P_RD: begin
				pt_re = 1'b1; pt_ra = cur_slot;
			end
			ACT_P_CHK: begin
				w_re = hit; w_ra = eff_src;
			end
			ACT_P_DEC: begin
				w_we = 1'b1; w_wa = s_q; w_wd = dec_val;
				q_we = push_q; q_wa = IW'(tail_q); q_wd = s_q;
			end
			ACT_CM_RD: begin
				e_re = 1'b1; e_ra = srcn;
			end
			ACT_CM_WR: begin
				e_we = 1'b1; e_wa = srcn; e_wd = edges_rd + CNT_W'(1);
				pt_we = 1'b1; pt_wa = slot_new; pt_wd = {1'b1, srcn};
			end
			ACT_EM_RD: begin
				q_re = 1'b1; q_ra = IW'(em_idx);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (act == ACT_LOAD) begin
			op_q  <= opcode;
			id_q  <= node_id;
			src_q <= source_node;
			prt_q <= port;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			i_q <= '0; n_q <= '0; s_q <= '0; p_q <= '0; k_q <= '0;
			head_q <= '0; tail_q <= '0; pc_q <= '0; s_ok_q <= 1'b0;
		end else begin
			unique case (act)
				ACT_INIT: begin
					i_q <= '0; p_q <= '0; k_q <= '0;
					head_q <= '0; tail_q <= '0; pc_q <= '0;
				end
				ACT_AN_CLR: begin
					p_q <= p_nxt;
					present_q[idn] <= 1'b1;
				end
				ACT_RN_PCHK: begin
					s_q    <= port_src;
					s_ok_q <= port_lnk && present_of(port_src);
					if (!port_lnk) p_q <= p_nxt;
				end
				ACT_RN_EDEC: p_q <= p_nxt;
				ACT_RN_SCHK: k_q <= k_q + SW'(1);
				ACT_RN_FIN:  present_q[idn] <= 1'b0;
				ACT_CP_WR: begin
					i_q  <= i_q + IW'(1);
					pc_q <= pc_q + CW'(present_q[i_q]);
					if (seed_q) tail_q <= tail_q + CW'(1);
				end
				ACT_SQ_N: begin
					n_q    <= queue_rd;
					head_q <= head_q + CW'(1);
					p_q    <= '0;
				end
				ACT_P_CHK: begin
					if (hit) s_q <= eff_src;
					else p_q <= p_nxt;
				end
				ACT_P_DEC: begin
					p_q <= p_nxt;
					if (push_q) tail_q <= tail_q + CW'(1);
				end
				ACT_CM_WR: i_q <= '0;
				ACT_EM_LD: i_q <= i_q + IW'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			priority case (act)
				ACT_EM_LD, ACT_OUT_DONE, ACT_OUT_MISS, ACT_OUT_CYC: out_valid_q <= 1'b1;
				default: if (rsp_ready) out_valid_q <= 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (act)
			ACT_EM_LD: begin
				out_status_q <= ST_ORDER;
				out_node_q   <= ID_W'(queue_rd);
				out_last_q   <= (CW'(i_q) + CW'(1)) == tail_q;
			end
			ACT_OUT_DONE: begin
				out_status_q <= ST_DONE; out_node_q <= '0; out_last_q <= 1'b1;
			end
			ACT_OUT_MISS: begin
				out_status_q <= ST_MISS; out_node_q <= '0; out_last_q <= 1'b1;
			end
			ACT_OUT_CYC: begin
				out_status_q <= ST_CYCLE; out_node_q <= '0; out_last_q <= 1'b1;
			end
			default: ;
		endcase
	end

	assign rsp_valid      = out_valid_q;
	assign rsp_status     = out_status_q;
	assign rsp_order_node = out_node_q;
	assign rsp_last       = out_last_q;

	dag_ram #(.WIDTH(CNT_W), .DEPTH(NODES)) u_edges (
		.clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd),
		.re(e_re), .raddr(e_ra), .rdata(edges_rd)
	);

	dag_ram #(.WIDTH(CNT_W), .DEPTH(NODES)) u_work (
		.clk(clk), .we(w_we), .waddr(w_wa), .wdata(w_wd),
		.re(w_re), .raddr(w_ra), .rdata(work_rd)
	);

	dag_ram #(.WIDTH(IW), .DEPTH(NODES)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd),
		.re(q_re), .raddr(q_ra), .rdata(queue_rd)
	);

	dag_ram #(.WIDTH(IW + 1), .DEPTH(SLOTS)) u_ports (
		.clk(clk), .we(pt_we), .waddr(pt_wa), .wdata(pt_wd),
		.re(pt_re), .raddr(pt_ra), .rdata(port_rd)
	);
endmodule
`default_nettype wire

// File: sv/dag_edge_insert_toposort.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dag_edge_insert_toposort: dataflow graph keeper with checked edge insert
// Holds up to NODES nodes with NODE_PORTS input ports each; add edge is
// accepted only if the graph stays acyclic, and then returns the run order.
// ----------------------------------------------------------------------------
// One operation is in flight at a time; a new request is taken once the
// previous one has loaded its final result into the output register. Counts,
// port links, work counts and the sort queue live in single-port-per-side
// RAMs, so each step does at most one read and one write per RAM. Add node
// clears its port row. Remove node clears its own ports, then sweeps every
// port slot looking for links to the node. Add edge decodes, copies the
// counts and seeds the queue, then takes each queued node and visits its
// ports, checks for the empty queue, commits and emits the run order entries.
// A rejected edge returns one status; an accepted one returns one entry per
// present node, sources first, last set on the final one. A stalled result
// register holds each result until it is taken. Port links of a node row are
// cleared by add node, so no clearing pass runs after reset.
module dag_edge_insert_toposort import dag_pkg::*; #(
	parameter int NODES      = NODES_DEF,
	parameter int NODE_PORTS = NODE_PORTS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	dag_req_if.sink     req,
	dag_rsp_if.source   rsp
);
	act_t     act;
	dp_stat_t stat;

	dag_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req.valid), .req_ready(req.ready),
		.stat(stat), .act(act)
	);

	dag_dp #(.NODES(NODES), .NODE_PORTS(NODE_PORTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .act(act),
		.opcode(req.opcode), .node_id(req.node_id),
		.source_node(req.source_node), .port(req.port),
		.stat(stat),
		.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
		.rsp_status(rsp.status), .rsp_order_node(rsp.order_node),
		.rsp_last(rsp.last)
	);
endmodule
`default_nettype wire

// File: sv/dag_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dag_chk: port-level checks for the graph keeper
// Request and result channel behavior as seen on the top level ports.
// ----------------------------------------------------------------------------
module dag_chk import dag_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_ready,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input logic [ST_W-1:0] rsp_status,
	input logic [ID_W-1:0] rsp_order_node,
	input logic            rsp_last
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_order_node) && $stable(rsp_last))
		else $error("result changed while stalled");

	a_status_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_ORDER |-> rsp_last && rsp_order_node == '0)
		else $error("status result not single or node nonzero");

	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while operation in flight");

	a_no_early_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !rsp_valid |=> !rsp_valid)
		else $error("result appeared in the cycle after a request");
endmodule

bind dag_edge_insert_toposort dag_chk u_dag_chk (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_status(rsp.status), .rsp_order_node(rsp.order_node),
	.rsp_last(rsp.last)
);
`default_nettype wire

// File: tb/sv/dag_tb_if.sv
// ----------------------------------------------------------------------------
// dag_tb_if: testbench channel note
// The request and result interfaces come from the RTL sources; this file only
// holds a small record type that the checker uses for its expected results.
// ----------------------------------------------------------------------------
package dag_tb_pkg;
	import dag_pkg::*;

	typedef struct packed {
		logic [ST_W-1:0] status;
		logic [ID_W-1:0] order_node;
		logic            last;
	} dag_result_t;
endpackage

// File: tb/sv/dag_graph_checker.sv
// ----------------------------------------------------------------------------
// dag_graph_checker: graph shadow and result scoreboard
// Keeps its own copy of the graph, computes the expected results (the run
// order for an accepted edge) and compares each result transfer in order.
// ----------------------------------------------------------------------------
module dag_graph_checker import dag_pkg::*; import dag_tb_pkg::*; #(
	parameter int NODES      = 32,
	parameter int NODE_PORTS = 8
) (
	input  logic  clk,
	input  logic  arst_n,
	dag_req_if    req,
	dag_rsp_if    rsp,
	output int    fail_count,
	output int    pending
);
	localparam int SLOTS     = NODES * NODE_PORTS;
	localparam int DUE_DEPTH = 256;

	bit              present [NODES];
	bit [CNT_W-1:0]  edges   [NODES];
	bit              linked  [SLOTS];
	bit [ID_W-1:0]   src_of  [SLOTS];
	dag_result_t     due     [DUE_DEPTH];
	int              due_wr;
	int              due_rd;

	assign pending = due_wr - due_rd;

	function automatic bit is_here(int id);
		return id < NODES && present[id];
	endfunction

	function automatic void drop_edge_count(int id);
		if (edges[id] != 0)
			edges[id] = edges[id] - 1'b1;
	endfunction

	function automatic void add_due(logic [ST_W-1:0] st, int n, bit l);
		dag_result_t r;
		r.status = st;
		r.order_node = n[ID_W-1:0];
		r.last = l;
		due[due_wr % DUE_DEPTH] = r;
		due_wr++;
	endfunction

	function automatic void try_edge(int dst, int src, int prt);
		bit [CNT_W-1:0] cnt [NODES];
		int order [NODES];
		int n_order, head, slot_new, n_here, s, slot;
		if (!is_here(dst) || !is_here(src) || prt >= NODE_PORTS) begin
			add_due(ST_MISS, 0, 1);
			return;
		end
		slot_new = dst * NODE_PORTS + prt;
		head = 0;
		n_here = 0;
		n_order = 0;
		for (int i = 0; i < NODES; i++)
			cnt[i] = edges[i];
		cnt[src] = cnt[src] + 1'b1;
		for (int i = 0; i < NODES; i++) begin
			if (!present[i])
				continue;
			n_here++;
			if (cnt[i] == 0) begin
				order[n_order] = i;
				n_order++;
			end
		end
		while (head < n_order) begin
			for (int p = 0; p < NODE_PORTS; p++) begin
				slot = order[head] * NODE_PORTS + p;
				if (slot == slot_new)
					s = src;
				else if (linked[slot])
					s = src_of[slot];
				else
					continue;
				if (!is_here(s))
					continue;
				cnt[s] = cnt[s] - 1'b1;	// wraps in 9 bits
				if (cnt[s] == 0 && n_order < NODES) begin
					order[n_order] = s;
					n_order++;
				end
			end
			head++;
		end
		if (n_order != n_here) begin
			add_due(ST_CYCLE, 0, 1);
			return;
		end
		edges[src] = edges[src] + 1'b1;
		linked[slot_new] = 1;
		src_of[slot_new] = src[ID_W-1:0];
		for (int i = n_order - 1; i >= 0; i--)
			add_due(ST_ORDER, order[i], i == 0);
	endfunction

	function automatic void apply_op(logic [OP_W-1:0] op, int id, int src, int prt);
		int slot;
		case (op)
			OP_ADD_EDGE: begin
				try_edge(id, src, prt);
				return;
			end
			OP_ADD_NODE: begin
				if (id < NODES) begin
					present[id] = 1;
					edges[id] = 0;
					for (int p = 0; p < NODE_PORTS; p++)
						linked[id * NODE_PORTS + p] = 0;
				end
			end
			OP_RM_EDGE: begin
				if (is_here(src))
					drop_edge_count(src);
				if (is_here(id) && prt < NODE_PORTS)
					linked[id * NODE_PORTS + prt] = 0;
			end
			default: begin
				if (is_here(id)) begin
					for (int p = 0; p < NODE_PORTS; p++) begin
						slot = id * NODE_PORTS + p;
						if (linked[slot]) begin
							if (is_here(src_of[slot]))
								drop_edge_count(src_of[slot]);
							linked[slot] = 0;
						end
					end
					for (int k = 0; k < SLOTS; k++)
						if (linked[k] && src_of[k] == id)
							linked[k] = 0;
					edges[id] = 0;
					present[id] = 0;
				end
			end
		endcase
		add_due(ST_DONE, 0, 1);
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH t=%0t %s: got %0d want %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		dag_result_t e;
		if (!arst_n) begin
			fail_count = 0;
			due_wr = 0;
			due_rd = 0;
			for (int i = 0; i < NODES; i++) begin
				present[i] = 0;
				edges[i] = 0;
			end
			for (int k = 0; k < SLOTS; k++) begin
				linked[k] = 0;
				src_of[k] = 0;
			end
		end else begin
			// result first: the request taken this edge cannot be answered yet
			if (rsp.valid && rsp.ready) begin
				if (due_wr == due_rd) begin
					report("unexpected result, status", rsp.status, 0);
				end else begin
					e = due[due_rd % DUE_DEPTH];
					due_rd++;
					if (rsp.status !== e.status)
						report("status", rsp.status, e.status);
					if (rsp.order_node !== e.order_node)
						report("order_node", rsp.order_node, e.order_node);
					if (rsp.last !== e.last)
						report("last", rsp.last, e.last);
				end
			end
			if (req.valid && req.ready)
				apply_op(req.opcode, req.node_id, req.source_node, req.port);
		end
	end
endmodule

// File: tb/sv/tb_dag_edge_insert_toposort.sv
// ----------------------------------------------------------------------------
// tb_dag_edge_insert_toposort: testbench top
// Drives graph operations with bursty valid and a stalling receiver; directed
// corners, a long stall, then mostly well-formed graph building with noise.
// ----------------------------------------------------------------------------
module tb_dag_edge_insert_toposort;
	import dag_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycles;
	bit   long_hold;

	dag_req_if req ();
	dag_rsp_if rsp ();

	dag_edge_insert_toposort dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));
	dag_graph_checker chk (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.fail_count(fail_count), .pending(pending));

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
	end

	// receiver stall pattern, with one long hold-off
	initial begin
		int mode;
		rsp.ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold)
				rsp.ready <= 0;
			else begin
				mode = (cycles / 500) % 3;
				if (mode == 0)
					rsp.ready <= 1;
				else if (mode == 1)
					rsp.ready <= ($urandom_range(3) != 0);
				else
					rsp.ready <= ($urandom_range(1) != 0);
			end
		end
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	int burst_left;

	// one transfer, with bursty gaps before it
	task automatic send(logic [OP_W-1:0] op, int id, int src, int prt);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(12);
			if (gap != 0) begin
				req.valid <= 0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 8);
		end
		req.valid       <= 1;
		req.opcode      <= op;
		req.node_id     <= id[ID_W-1:0];
		req.source_node <= src[ID_W-1:0];
		req.port        <= prt[PORT_W-1:0];
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		burst_left--;
	endtask

	task automatic drain();
		req.valid <= 0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		int n, a, b, r;
		long_hold = 0;
		burst_left = 0;
		req.valid = 0;
		req.opcode = OP_ADD_NODE;
		req.node_id = 0;
		req.source_node = 0;
		req.port = 0;
		@(posedge arst_n);
		@(posedge clk);

		// directed corners
		send(OP_ADD_EDGE, 0, 1, 0);      // both absent
		send(OP_RM_NODE, 5, 0, 0);       // absent node
		send(OP_ADD_NODE, 0, 0, 0);
		send(OP_ADD_NODE, 31, 0, 0);
		send(OP_ADD_NODE, 1, 0, 0);
		send(OP_ADD_EDGE, 31, 0, 7);     // 0 -> 31
		send(OP_ADD_EDGE, 1, 31, 0);     // 31 -> 1
		send(OP_ADD_EDGE, 0, 1, 3);      // closes a cycle
		send(OP_ADD_EDGE, 0, 0, 2);      // self loop
		send(OP_ADD_EDGE, 1, 0, 0);      // rewrite occupied port
		send(OP_ADD_EDGE, 1, 7, 1);      // absent source
		send(OP_RM_EDGE, 1, 0, 0);
		send(OP_RM_EDGE, 1, 0, 0);       // same edge removed again
		send(OP_RM_EDGE, 9, 20, 5);
		send(OP_ADD_NODE, 31, 0, 0);     // re-add clears ports and count
		send(OP_ADD_EDGE, 31, 1, 5);
		send(OP_RM_NODE, 1, 0, 0);
		send(OP_RM_NODE, 31, 0, 0);
		send(OP_RM_NODE, 0, 0, 0);
		drain();

		// long receiver hold while requests keep coming
		fork
			begin
				long_hold = 1;
				repeat (3000) @(posedge clk);
				long_hold = 0;
			end
			for (int i = 0; i < 10; i++)
				send(OP_ADD_NODE, i, 0, 0);
		join
		drain();

		// random graph building: mostly sane edges among a small node pool
		for (int i = 0; i < 90; i++) begin
			r = $urandom_range(99);
			n = $urandom_range(31);
			a = $urandom_range(31);
			b = $urandom_range(7);
			if (r < 15)
				send(OP_ADD_NODE, $urandom_range(15), 0, 0);
			else if (r < 70) begin
				// lower id feeding higher keeps most edges acyclic
				if (a > n && $urandom_range(3) != 0) begin
					int t;
					t = a; a = n; n = t;
				end
				send(OP_ADD_EDGE, n % 16, a % 16, b);
			end else if (r < 82)
				send(OP_RM_EDGE, n % 16, a % 16, b);
			else if (r < 90)
				send(OP_RM_NODE, n % 16, 0, 0);
			else
				send(OP_W'($urandom_range(3)), n, a, b);
			if (i == 45)
				drain();
		end
		drain();
		repeat (50) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
